### rtl/assert_macros.svh
// Assertion macros included by the encoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/irac_pkg.sv
// Package: widths, register codes, reset values and the sequencer program.
package irac_pkg;

  localparam int DurW      = 14;
  localparam int AddrW     = 12;
  localparam int DataBits  = 56;
  localparam int CntW      = 6;
  localparam int CfgIdxW   = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_ADDR        = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HDR_MARK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HDR_SPACE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIT_MARK    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ZERO_SPACE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ONE_SPACE   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TRL_MARK    = 3'd6;

  localparam logic [DurW-1:0] RST_HDR_MARK   = 14'd3000;
  localparam logic [DurW-1:0] RST_HDR_SPACE  = 14'd9000;
  localparam logic [DurW-1:0] RST_BIT_MARK   = 14'd500;
  localparam logic [DurW-1:0] RST_ZERO_SPACE = 14'd560;
  localparam logic [DurW-1:0] RST_ONE_SPACE  = 14'd1570;
  localparam logic [DurW-1:0] RST_TRL_MARK   = 14'd500;

  // Input function codes and timer kinds
  localparam logic       FUNC_STATE     = 1'b0;
  localparam logic [3:0] KIND_OFF_TIMER = 4'h4;
  localparam logic [3:0] KIND_ON_TIMER  = 4'h2;
  localparam logic [3:0] TIMER_MARKER   = 4'hF;
  localparam logic [5:0] TIMER_SUM_BASE = 6'd3;

  // Program steps
  localparam logic [1:0] STEP_WAIT    = 2'd0;
  localparam logic [1:0] STEP_HEADER  = 2'd1;
  localparam logic [1:0] STEP_BITS    = 2'd2;
  localparam logic [1:0] STEP_TRAILER = 2'd3;

  // Pair source selects
  localparam logic [1:0] EMIT_NONE    = 2'd0;
  localparam logic [1:0] EMIT_HEADER  = 2'd1;
  localparam logic [1:0] EMIT_BIT     = 2'd2;
  localparam logic [1:0] EMIT_TRAILER = 2'd3;

  typedef struct packed {
    logic       wait_in;   // step takes a command
    logic [1:0] emit;      // pair source
    logic       cnt_load;  // load bit counter
    logic       cnt_loop;  // repeat step until counter is zero
    logic [1:0] next_step;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode(input logic [1:0] step);
    ctrl_word_t cw;
    cw = '0;
    case (step)
      STEP_WAIT: begin
        cw.wait_in   = 1'b1;
        cw.next_step = STEP_HEADER;
      end
      STEP_HEADER: begin
        cw.emit      = EMIT_HEADER;
        cw.cnt_load  = 1'b1;
        cw.next_step = STEP_BITS;
      end
      STEP_BITS: begin
        cw.emit      = EMIT_BIT;
        cw.cnt_loop  = 1'b1;
        cw.next_step = STEP_TRAILER;
      end
      STEP_TRAILER: begin
        cw.emit      = EMIT_TRAILER;
        cw.next_step = STEP_WAIT;
      end
      default: cw = '0;
    endcase
    return cw;
  endfunction

endpackage

### rtl/ir_ac_state_frame_encoder.sv
// Top level: IR air-conditioner frame encoder driven by a small microprogram.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  cmd     | in        | in_valid / in_stall  | func, settings, timer fields
//  pairs   | out       | out_valid / out_stall| mark_us, space_us, last
//  config  | in        | cfg_we               | cfg_index, cfg_data
//
// A command is taken in the wait step, then 58 pairs follow at one per cycle
// while the output does not stall. The wait step plus one step per pair sets
// this pace. A stall on the output holds the current step. Reset returns to
// the wait step and loads the default durations and address 0.
`include "assert_macros.svh"

module ir_ac_state_frame_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [irac_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [irac_pkg::DurW-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [7:0]                          swing_setting,
  input  logic [7:0]                          turbo_setting,
  input  logic [7:0]                          temp_setting,
  input  logic [3:0]                          fan_speed,
  input  logic [3:0]                          op_mode,
  input  logic [3:0]                          clean_setting,
  input  logic [3:0]                          power_setting,
  input  logic [3:0]                          timer_kind,
  input  logic [5:0]                          timer_hour_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [irac_pkg::DurW-1:0]           mark_us,
  output logic [irac_pkg::DurW-1:0]           space_us,
  output logic                                last
);

  // configuration registers
  logic [irac_pkg::AddrW-1:0] dev_addr;
  logic [irac_pkg::DurW-1:0]  hdr_mark, hdr_space, bit_mark;
  logic [irac_pkg::DurW-1:0]  zero_space, one_space, trl_mark;

  // sequencer and datapath
  logic [1:0]                    step, step_next;
  logic [irac_pkg::CntW-1:0]     cnt;
  logic [irac_pkg::DataBits-1:0] frame;
  logic [irac_pkg::DataBits-1:0] frame_next;
  irac_pkg::ctrl_word_t          cw;
  logic                          in_acc, out_free, step_go, stay, emit_go;
  logic [irac_pkg::DurW-1:0]     pair_mark, pair_space;
  logic                          pair_last;

  logic [5:0] ones, sum;
  logic [3:0] chk;
  logic [7:0] off_slot, on_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr   <= '0;
      hdr_mark   <= irac_pkg::RST_HDR_MARK;
      hdr_space  <= irac_pkg::RST_HDR_SPACE;
      bit_mark   <= irac_pkg::RST_BIT_MARK;
      zero_space <= irac_pkg::RST_ZERO_SPACE;
      one_space  <= irac_pkg::RST_ONE_SPACE;
      trl_mark   <= irac_pkg::RST_TRL_MARK;
    end else if (cfg_we) begin
      case (cfg_index)
        irac_pkg::REG_ADDR:       dev_addr   <= cfg_data[irac_pkg::AddrW-1:0];
        irac_pkg::REG_HDR_MARK:   hdr_mark   <= cfg_data;
        irac_pkg::REG_HDR_SPACE:  hdr_space  <= cfg_data;
        irac_pkg::REG_BIT_MARK:   bit_mark   <= cfg_data;
        irac_pkg::REG_ZERO_SPACE: zero_space <= cfg_data;
        irac_pkg::REG_ONE_SPACE:  one_space  <= cfg_data;
        irac_pkg::REG_TRL_MARK:   trl_mark   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame assembly, bit 0 goes out first
  always_comb begin
    off_slot = (timer_kind == irac_pkg::KIND_OFF_TIMER) ? {timer_hour_count, 2'b00} : 8'h00;
    on_slot  = (timer_kind == irac_pkg::KIND_ON_TIMER)  ? {timer_hour_count, 2'b00} : 8'h00;
    if (func == irac_pkg::FUNC_STATE) begin
      ones = 6'($countones({swing_setting, turbo_setting, temp_setting,
                            fan_speed, op_mode, clean_setting, power_setting}));
      sum  = ones;
    end else begin
      ones = 6'($countones({timer_kind, timer_hour_count}));
      sum  = irac_pkg::TIMER_SUM_BASE + ones;
    end
    chk = 4'(6'd0 - sum);
    if (func == irac_pkg::FUNC_STATE) begin
      frame_next = {power_setting, clean_setting, op_mode, fan_speed,
                    temp_setting, turbo_setting, swing_setting, chk, dev_addr};
    end else begin
      frame_next = {12'h000, timer_kind, 4'h0, on_slot, off_slot,
                    irac_pkg::TIMER_MARKER, chk, dev_addr};
    end
  end

  // control word decode
  always_comb begin
    cw        = irac_pkg::ucode(step);
    in_acc    = in_valid && cw.wait_in;
    out_free  = !out_valid || !out_stall;
    emit_go   = (cw.emit != irac_pkg::EMIT_NONE) && out_free;
    step_go   = cw.wait_in ? in_valid : ((cw.emit == irac_pkg::EMIT_NONE) || out_free);
    stay      = cw.cnt_loop && (cnt != '0);
    step_next = (step_go && !stay) ? cw.next_step : step;
    case (cw.emit)
      irac_pkg::EMIT_HEADER: begin
        pair_mark  = hdr_mark;
        pair_space = hdr_space;
        pair_last  = 1'b0;
      end
      irac_pkg::EMIT_BIT: begin
        pair_mark  = bit_mark;
        pair_space = frame[0] ? one_space : zero_space;
        pair_last  = 1'b0;
      end
      irac_pkg::EMIT_TRAILER: begin
        pair_mark  = trl_mark;
        pair_space = '0;
        pair_last  = 1'b1;
      end
      default: begin
        pair_mark  = '0;
        pair_space = '0;
        pair_last  = 1'b0;
      end
    endcase
  end

  assign in_stall = !cw.wait_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= irac_pkg::STEP_WAIT;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      frame <= frame_next;
    end else if (emit_go && cw.emit == irac_pkg::EMIT_BIT) begin
      frame <= frame >> 1;
    end
    // load the bit count, count down through the data bits
    if (step_go && cw.cnt_load) begin
      cnt <= irac_pkg::CntW'(irac_pkg::DataBits - 1);
    end else if (step_go && stay) begin
      cnt <= cnt - 1'b1;
    end
    if (emit_go) begin
      mark_us  <= pair_mark;
      space_us <= pair_space;
      last     <= pair_last;
    end
  end

  `ASSERT_IMPLY(a_trl_space, clk, rst, out_valid && last, space_us == '0, "trailer space nonzero")
  `ASSERT_NEXT(a_bits_done, clk, rst, step == irac_pkg::STEP_BITS && cnt == '0 && out_free, step == irac_pkg::STEP_TRAILER, "bit loop did not exit to trailer")
  `ASSERT_NEXT(a_cmd_start, clk, rst, in_valid && !in_stall, step == irac_pkg::STEP_HEADER, "accepted command did not start a frame")

endmodule
